### hdl/mcfsm_pkg.sv
// Shared types and constants for the multicycle control state machine.
`timescale 1ns / 1ps
`default_nettype none

package mcfsm_pkg;

    // Opcode codes held in the configuration registers.
    localparam int NumCodes = 7;
    localparam int CodeW    = 6;
    localparam int CfgIdxW  = 3;

    typedef logic [CodeW-1:0] t_code;

    // Reset values in register order: rtype, lw, sw, beq, bne, li, j.
    localparam t_code CodeReset [NumCodes] = '{
        6'd0, 6'd35, 6'd43, 6'd4, 6'd5, 6'd15, 6'd2
    };

    // Instruction class, in match priority order.
    typedef enum logic [2:0] {
        K_RTYPE = 3'd0,
        K_LW    = 3'd1,
        K_SW    = 3'd2,
        K_BEQ   = 3'd3,
        K_BNE   = 3'd4,
        K_LI    = 3'd5,
        K_J     = 3'd6,
        K_NONE  = 3'd7
    } t_kind;

    // Control states.
    typedef enum logic [3:0] {
        ST_FETCH   = 4'd0,
        ST_DECODE  = 4'd1,
        ST_ADDR    = 4'd2,
        ST_LW_ACC  = 4'd3,
        ST_SW_ACC  = 4'd4,
        ST_RD_DONE = 4'd5,
        ST_EXEC    = 4'd6,
        ST_R_DONE  = 4'd7,
        ST_BRANCH  = 4'd8,
        ST_JUMP    = 4'd9,
        ST_LI      = 4'd10,
        ST_LI_DONE = 4'd11
    } t_state;

    // Write enable bits.
    localparam logic [5:0] WeIr     = 6'b000001;
    localparam logic [5:0] WeReg    = 6'b000010;
    localparam logic [5:0] WeMemRd  = 6'b000100;
    localparam logic [5:0] WeMemWr  = 6'b001000;
    localparam logic [5:0] WePc     = 6'b010000;
    localparam logic [5:0] WeAluOut = 6'b100000;

    // Selector codes.
    localparam logic [1:0] SrcBReg   = 2'd0;
    localparam logic [1:0] SrcBFour  = 2'd1;
    localparam logic [1:0] SrcBImm   = 2'd2;
    localparam logic [1:0] SrcBShImm = 2'd3;

    localparam logic [1:0] AluAdd  = 2'd0;
    localparam logic [1:0] AluSub  = 2'd1;
    localparam logic [1:0] AluFunc = 2'd2;

    localparam logic [1:0] PcAluRes = 2'd0;
    localparam logic [1:0] PcAluOut = 2'd1;
    localparam logic [1:0] PcJump   = 2'd2;

    localparam logic [1:0] CondNone = 2'd0;
    localparam logic [1:0] CondEq   = 2'd1;
    localparam logic [1:0] CondNe   = 2'd2;

    // One beat of datapath control.
    typedef struct packed {
        logic [3:0] cycle_state;
        logic [5:0] write_enables;
        logic       reg_dst;
        logic       mem_to_reg;
        logic       reg_data_src;
        logic       addr_from_data;
        logic       alu_src_a;
        logic [1:0] alu_src_b;
        logic [1:0] alu_op;
        logic [1:0] pc_source;
        logic [1:0] pc_write_cond;
    } t_ctrl;

endpackage

`default_nettype wire

### hdl/mcfsm_decode.sv
// Opcode configuration registers and priority opcode classifier.
`timescale 1ns / 1ps
`default_nettype none

module mcfsm_decode
    import mcfsm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr_en,
    input  wire logic [CfgIdxW-1:0] i_wr_index,
    input  wire t_code              i_wr_data,
    input  wire t_code              i_opcode,
    output t_kind                   o_kind
);

    t_code r_codes [NumCodes];

    // Configuration writes; indexes past the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NumCodes; k++) begin
                r_codes[k] <= CodeReset[k];
            end
        end else if (i_wr_en && (32'(i_wr_index) < NumCodes)) begin
            r_codes[i_wr_index] <= i_wr_data;
        end
    end

    // First match in priority order wins, so scan from the lowest priority up.
    always_comb begin
        o_kind = K_NONE;
        for (int k = NumCodes - 1; k >= 0; k--) begin
            if (i_opcode == r_codes[k]) begin
                o_kind = t_kind'(3'(k));
            end
        end
    end

endmodule

`default_nettype wire

### hdl/mcfsm_ctrl.sv
// Control state register with next-state and output decoding.
`timescale 1ns / 1ps
`default_nettype none

module mcfsm_ctrl
    import mcfsm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_advance,
    input  wire t_kind i_kind,
    output t_ctrl     o_ctrl
);

    t_state r_state;
    t_state n_state;

    // State advances once per beat that moves to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FETCH;
        end else if (i_advance) begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = ST_FETCH;
        case (r_state)
            ST_FETCH: begin
                n_state = ST_DECODE;
            end
            ST_DECODE: begin
                case (i_kind)
                    K_LW, K_SW:   n_state = ST_ADDR;
                    K_RTYPE:      n_state = ST_EXEC;
                    K_BEQ, K_BNE: n_state = ST_BRANCH;
                    K_LI:         n_state = ST_LI;
                    K_J:          n_state = ST_JUMP;
                    default:      n_state = ST_DECODE;
                endcase
            end
            ST_ADDR: begin
                case (i_kind)
                    K_LW:    n_state = ST_LW_ACC;
                    K_SW:    n_state = ST_SW_ACC;
                    default: n_state = ST_ADDR;
                endcase
            end
            ST_LW_ACC: n_state = ST_RD_DONE;
            ST_EXEC:   n_state = ST_R_DONE;
            ST_LI:     n_state = ST_LI_DONE;
            default:   n_state = ST_FETCH;
        endcase
    end

    // Datapath control for the present state; undriven signals stay zero.
    always_comb begin
        o_ctrl             = '0;
        o_ctrl.cycle_state = r_state;
        case (r_state)
            ST_FETCH: begin
                o_ctrl.write_enables = WeIr | WeMemRd | WePc;
                o_ctrl.alu_src_b     = SrcBFour;
            end
            ST_DECODE: begin
                o_ctrl.write_enables = WeAluOut;
                o_ctrl.alu_src_b     = SrcBShImm;
            end
            ST_ADDR: begin
                o_ctrl.write_enables = WeAluOut;
                o_ctrl.alu_src_a     = 1'b1;
                o_ctrl.alu_src_b     = SrcBImm;
            end
            ST_LW_ACC: begin
                o_ctrl.write_enables  = WeMemRd;
                o_ctrl.addr_from_data = 1'b1;
            end
            ST_SW_ACC: begin
                o_ctrl.write_enables  = WeMemWr;
                o_ctrl.addr_from_data = 1'b1;
            end
            ST_RD_DONE: begin
                o_ctrl.write_enables = WeReg;
                o_ctrl.mem_to_reg    = 1'b1;
            end
            ST_EXEC: begin
                o_ctrl.write_enables = WeAluOut;
                o_ctrl.alu_src_a     = 1'b1;
                o_ctrl.alu_op        = AluFunc;
            end
            ST_R_DONE: begin
                o_ctrl.write_enables = WeReg;
                o_ctrl.reg_dst       = 1'b1;
            end
            ST_BRANCH: begin
                o_ctrl.alu_src_a = 1'b1;
                o_ctrl.alu_op    = AluSub;
                o_ctrl.pc_source = PcAluOut;
                case (i_kind)
                    K_BEQ:   o_ctrl.pc_write_cond = CondEq;
                    K_BNE:   o_ctrl.pc_write_cond = CondNe;
                    default: o_ctrl.pc_write_cond = CondNone;
                endcase
            end
            ST_JUMP: begin
                o_ctrl.write_enables = WePc;
                o_ctrl.pc_source     = PcJump;
            end
            ST_LI: begin
                o_ctrl.write_enables = WeAluOut;
                o_ctrl.reg_data_src  = 1'b1;
                o_ctrl.alu_src_a     = 1'b1;
                o_ctrl.alu_src_b     = SrcBImm;
            end
            ST_LI_DONE: begin
                o_ctrl.write_enables = WeReg;
            end
            default: begin
                o_ctrl.write_enables = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/multicycle_cpu_control_fsm_unit.sv
// Top level of the multicycle control state machine with input and result registers.
// Input register holds the opcode beat; result register holds its control beat.
// Throughput: one beat per cycle when not stalled; the state advances once per beat.
// Stall on the result side backs up through the input register to o_in_stall.
// Synchronous active-low reset: state returns to fetch, opcode codes to defaults.
// No clearing pass; the block accepts beats as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module multicycle_cpu_control_fsm_unit
    import mcfsm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Opcode channel.
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [5:0]         i_opcode_field,
    // Control result channel.
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [3:0]              o_cycle_state,
    output logic [5:0]              o_write_enables,
    output logic                    o_reg_dst,
    output logic                    o_mem_to_reg,
    output logic                    o_reg_data_src,
    output logic                    o_addr_from_data,
    output logic                    o_alu_src_a,
    output logic [1:0]              o_alu_src_b,
    output logic [1:0]              o_alu_op,
    output logic [1:0]              o_pc_source,
    output logic [1:0]              o_pc_write_cond,
    // Configuration write channel.
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CfgIdxW-1:0] i_cfg_index,
    input  wire logic [5:0]         i_cfg_data
);

    logic  r_in_valid;
    t_code r_in_opcode;
    logic  r_out_valid;
    t_ctrl r_out;

    logic  out_free;
    logic  advance;
    logic  in_accept;
    t_kind kind;
    t_ctrl ctrl;

    // Handshake: a beat moves on when the result register is empty or drains.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_opcode <= i_opcode_field;
        end
    end

    mcfsm_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .i_opcode   (r_in_opcode),
        .o_kind     (kind)
    );

    mcfsm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_kind    (kind),
        .o_ctrl    (ctrl)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= ctrl;
        end
    end

    // Result fields.
    assign o_out_valid      = r_out_valid;
    assign o_cycle_state    = r_out.cycle_state;
    assign o_write_enables  = r_out.write_enables;
    assign o_reg_dst        = r_out.reg_dst;
    assign o_mem_to_reg     = r_out.mem_to_reg;
    assign o_reg_data_src   = r_out.reg_data_src;
    assign o_addr_from_data = r_out.addr_from_data;
    assign o_alu_src_a      = r_out.alu_src_a;
    assign o_alu_src_b      = r_out.alu_src_b;
    assign o_alu_op         = r_out.alu_op;
    assign o_pc_source      = r_out.pc_source;
    assign o_pc_write_cond  = r_out.pc_write_cond;

endmodule

`default_nettype wire

### tb/sv/tb_multicycle_cpu_control_fsm_unit.sv
// Self-checking testbench for the multicycle control state machine unit.
`timescale 1ns / 1ps

module tb_multicycle_cpu_control_fsm_unit
    import mcfsm_pkg::*;
();

    localparam t_code OpAllOnes = '1;
    localparam t_code OpAllZero = '0;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [5:0]          i_opcode_field;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [3:0]          o_cycle_state;
    logic [5:0]          o_write_enables;
    logic                o_reg_dst;
    logic                o_mem_to_reg;
    logic                o_reg_data_src;
    logic                o_addr_from_data;
    logic                o_alu_src_a;
    logic [1:0]          o_alu_src_b;
    logic [1:0]          o_alu_op;
    logic [1:0]          o_pc_source;
    logic [1:0]          o_pc_write_cond;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [5:0]          i_cfg_data;

    multicycle_cpu_control_fsm_unit DUT (.*);

    // Shadow copy of the control state and the opcode code registers.
    t_state ctl_state;
    t_code  op_codes [NumCodes];

    // Control beats predicted for accepted opcode beats, oldest first.
    t_ctrl  expected_ctrl [$];

    int     fail_count;
    int     opcode_beats;
    int     control_beats;
    int     code_writes;
    int     state_hits [16];
    bit     idle_on;
    bit     stall_on;
    int     stall_left;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the handshakes hang.
    initial begin
        #(10_000_000);
        $display("Timeout: %0d control beats still outstanding.", expected_ctrl.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Match an opcode against the code registers in priority order.
    function automatic t_kind classify_opcode(t_code op);
        for (int k = 0; k < NumCodes; k++) begin
            if (op == op_codes[k]) begin
                return t_kind'(k);
            end
        end
        return K_NONE;
    endfunction

    // Control signals of the present state, then advance the shadow state.
    function automatic t_ctrl step_control(t_code op);
        t_ctrl  c;
        t_kind  kind;
        t_state nxt;
        kind          = classify_opcode(op);
        c             = '0;
        c.cycle_state = ctl_state;
        nxt           = ST_FETCH;
        case (ctl_state)
            ST_FETCH: begin
                c.write_enables = WeIr | WeMemRd | WePc;
                c.alu_src_b     = SrcBFour;
                nxt             = ST_DECODE;
            end
            ST_DECODE: begin
                c.write_enables = WeAluOut;
                c.alu_src_b     = SrcBShImm;
                case (kind)
                    K_LW, K_SW:   nxt = ST_ADDR;
                    K_RTYPE:      nxt = ST_EXEC;
                    K_BEQ, K_BNE: nxt = ST_BRANCH;
                    K_LI:         nxt = ST_LI;
                    K_J:          nxt = ST_JUMP;
                    default:      nxt = ST_DECODE;
                endcase
            end
            ST_ADDR: begin
                c.write_enables = WeAluOut;
                c.alu_src_a     = 1'b1;
                c.alu_src_b     = SrcBImm;
                if (kind == K_LW) begin
                    nxt = ST_LW_ACC;
                end else if (kind == K_SW) begin
                    nxt = ST_SW_ACC;
                end else begin
                    nxt = ST_ADDR;
                end
            end
            ST_LW_ACC: begin
                c.write_enables  = WeMemRd;
                c.addr_from_data = 1'b1;
                nxt              = ST_RD_DONE;
            end
            ST_SW_ACC: begin
                c.write_enables  = WeMemWr;
                c.addr_from_data = 1'b1;
            end
            ST_RD_DONE: begin
                c.write_enables = WeReg;
                c.mem_to_reg    = 1'b1;
            end
            ST_EXEC: begin
                c.write_enables = WeAluOut;
                c.alu_src_a     = 1'b1;
                c.alu_op        = AluFunc;
                nxt             = ST_R_DONE;
            end
            ST_R_DONE: begin
                c.write_enables = WeReg;
                c.reg_dst       = 1'b1;
            end
            ST_BRANCH: begin
                c.alu_src_a = 1'b1;
                c.alu_op    = AluSub;
                c.pc_source = PcAluOut;
                if (kind == K_BEQ) begin
                    c.pc_write_cond = CondEq;
                end else if (kind == K_BNE) begin
                    c.pc_write_cond = CondNe;
                end else begin
                    c.pc_write_cond = CondNone;
                end
            end
            ST_JUMP: begin
                c.write_enables = WePc;
                c.pc_source     = PcJump;
            end
            ST_LI: begin
                c.write_enables = WeAluOut;
                c.reg_data_src  = 1'b1;
                c.alu_src_a     = 1'b1;
                c.alu_src_b     = SrcBImm;
                nxt             = ST_LI_DONE;
            end
            ST_LI_DONE: begin
                c.write_enables = WeReg;
            end
            default: begin
            end
        endcase
        ctl_state = nxt;
        return c;
    endfunction

    // List every field where the observed beat differs from the prediction.
    function automatic string ctrl_diff(t_ctrl e, t_ctrl a);
        string s;
        s = "";
        if (a.cycle_state !== e.cycle_state)
            s = {s, $sformatf(" cycle_state %0d/%0d", e.cycle_state, a.cycle_state)};
        if (a.write_enables !== e.write_enables)
            s = {s, $sformatf(" write_enables %b/%b", e.write_enables, a.write_enables)};
        if (a.reg_dst !== e.reg_dst)
            s = {s, $sformatf(" reg_dst %b/%b", e.reg_dst, a.reg_dst)};
        if (a.mem_to_reg !== e.mem_to_reg)
            s = {s, $sformatf(" mem_to_reg %b/%b", e.mem_to_reg, a.mem_to_reg)};
        if (a.reg_data_src !== e.reg_data_src)
            s = {s, $sformatf(" reg_data_src %b/%b", e.reg_data_src, a.reg_data_src)};
        if (a.addr_from_data !== e.addr_from_data)
            s = {s, $sformatf(" addr_from_data %b/%b", e.addr_from_data, a.addr_from_data)};
        if (a.alu_src_a !== e.alu_src_a)
            s = {s, $sformatf(" alu_src_a %b/%b", e.alu_src_a, a.alu_src_a)};
        if (a.alu_src_b !== e.alu_src_b)
            s = {s, $sformatf(" alu_src_b %0d/%0d", e.alu_src_b, a.alu_src_b)};
        if (a.alu_op !== e.alu_op)
            s = {s, $sformatf(" alu_op %0d/%0d", e.alu_op, a.alu_op)};
        if (a.pc_source !== e.pc_source)
            s = {s, $sformatf(" pc_source %0d/%0d", e.pc_source, a.pc_source)};
        if (a.pc_write_cond !== e.pc_write_cond)
            s = {s, $sformatf(" pc_write_cond %0d/%0d", e.pc_write_cond, a.pc_write_cond)};
        return s;
    endfunction

    // Check every accepted control beat against the oldest prediction.
    always @(posedge i_clk) begin : check_control
        t_ctrl act;
        t_ctrl exp_beat;
        string diff;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            act = {o_cycle_state, o_write_enables, o_reg_dst, o_mem_to_reg, o_reg_data_src,
                   o_addr_from_data, o_alu_src_a, o_alu_src_b, o_alu_op, o_pc_source,
                   o_pc_write_cond};
            control_beats++;
            state_hits[o_cycle_state]++;
            if (expected_ctrl.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: control beat with no opcode beat pending", $realtime);
            end else begin
                exp_beat = expected_ctrl.pop_front();
                diff     = ctrl_diff(exp_beat, act);
                if (diff != "") begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: control beat %0d (expected/actual):%s",
                                 $realtime, control_beats, diff);
                end
            end
        end
    end

    // Result-side stall: mostly short bursts, now and then a long one.
    always @(posedge i_clk) begin : drive_stall
        int r;
        r = $urandom_range(0, 99);
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (!stall_on || r < 65) begin
            i_out_stall <= 1'b0;
        end else if (r < 95) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(8, 30);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_code pick_code();
        return op_codes[$urandom_range(0, NumCodes - 1)];
    endfunction

    // Send one opcode beat and record the control beat it should produce.
    task automatic send_opcode(input t_code op);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode_field <= op;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_ctrl.push_back(step_control(op));
        opcode_beats++;
    endtask

    // Hold the sender off until every predicted beat has come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_ctrl.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_code(input logic [CfgIdxW-1:0] idx, input t_code value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx < NumCodes)
            op_codes[idx] = value;
        code_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_codes(input t_code vals [NumCodes]);
        wait_idle();
        for (int k = 0; k < NumCodes; k++)
            write_code(CfgIdxW'(k), vals[k]);
    endtask

    // Instruction streams: the opcode is mostly held for a whole instruction,
    // with a share of random beats mixed in as noise.
    task automatic run_stream(input int n_items, input int noise_pct);
        t_code cur_op;
        t_code op;
        cur_op = pick_code();
        for (int i = 0; i < n_items; i++) begin
            if (ctl_state == ST_FETCH) begin
                cur_op = ($urandom_range(0, 99) < 85) ? pick_code()
                                                      : t_code'($urandom_range(0, 63));
            end else if (ctl_state == ST_DECODE && classify_opcode(cur_op) == K_NONE
                         && $urandom_range(0, 3) == 0) begin
                cur_op = pick_code();
            end
            op = ($urandom_range(0, 99) < noise_pct) ? t_code'($urandom_range(0, 63)) : cur_op;
            send_opcode(op);
        end
    endtask

    // Walk every instruction class with the reset codes, including an
    // unknown opcode in decode, a bad opcode in the address state and a
    // branch whose opcode is neither branch code.
    task automatic test_directed_walk();
        t_code walk [$];
        walk = {OpAllOnes, OpAllOnes, op_codes[K_RTYPE], op_codes[K_RTYPE], op_codes[K_RTYPE],
                op_codes[K_LW], op_codes[K_LW], OpAllOnes, op_codes[K_LW], op_codes[K_LW],
                op_codes[K_LW],
                op_codes[K_SW], op_codes[K_SW], op_codes[K_SW], op_codes[K_SW],
                op_codes[K_BEQ], op_codes[K_BEQ], op_codes[K_BEQ],
                op_codes[K_BNE], op_codes[K_BNE], op_codes[K_BNE],
                op_codes[K_BEQ], op_codes[K_BEQ], OpAllOnes,
                op_codes[K_LI], op_codes[K_LI], op_codes[K_LI], op_codes[K_LI],
                op_codes[K_J], op_codes[K_J], OpAllZero};
        foreach (walk[i])
            send_opcode(walk[i]);
    endtask

    // Reset codes: a quiet stretch, then idling on both sides with a pause
    // for the pipeline to drain halfway through.
    task automatic test_default_codes();
        idle_on  = 1'b0;
        stall_on = 1'b0;
        run_stream(100, 10);
        idle_on  = 1'b1;
        stall_on = 1'b1;
        run_stream(200, 10);
        wait_idle();
        run_stream(200, 15);
    endtask

    // Extreme values in every register, and writes to the index past the last one.
    task automatic test_remapped_codes();
        set_codes('{6'd63, 6'd0, 6'd62, 6'd1, 6'd61, 6'd2, 6'd60});
        write_code(K_NONE, OpAllOnes);
        run_stream(175, 10);
        wait_idle();
        write_code(K_NONE, OpAllZero);
        run_stream(175, 10);
    endtask

    // Shared codes: the earlier register in priority order must win.
    task automatic test_colliding_codes();
        set_codes('{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0});
        run_stream(100, 20);
        set_codes('{6'd1, 6'd9, 6'd9, 6'd17, 6'd17, 6'd33, 6'd33});
        run_stream(250, 10);
    endtask

    // Random code maps, then every register at its maximum, then reset values.
    task automatic test_random_code_maps();
        t_code vals [NumCodes];
        for (int round = 0; round < 3; round++) begin
            foreach (vals[k])
                vals[k] = t_code'($urandom_range(0, 63));
            set_codes(vals);
            run_stream(200, 10);
        end
        set_codes('{6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63});
        run_stream(100, 10);
        set_codes(CodeReset);
        run_stream(50, 10);
    endtask

    initial begin
        int reached;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_opcode_field <= '0;
        i_out_stall    <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        ctl_state      = ST_FETCH;
        op_codes       = CodeReset;
        idle_on        = 1'b1;
        stall_on       = 1'b1;
        stall_left     = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_walk();
        test_default_codes();
        test_remapped_codes();
        test_colliding_codes();
        test_random_code_maps();

        // Drain, then watch a little longer for stray beats.
        wait_idle();
        repeat (10) @(posedge i_clk);
        fail_count += expected_ctrl.size();

        reached = 0;
        foreach (state_hits[s])
            if (state_hits[s] > 0)
                reached++;
        $display("Sent %0d opcode beats and checked %0d control beats.",
                 opcode_beats, control_beats);
        $display("Made %0d code register writes; %0d of 12 control states were visited.",
                 code_writes, reached);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d failures.", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
